FILE: rtl/cyclic_rotation_shift_finder_unit_macros.svh
// Assertion macros shared by the rotation finder checker.
`ifndef CYCLIC_ROTATION_SHIFT_FINDER_UNIT_MACROS_SVH
`define CYCLIC_ROTATION_SHIFT_FINDER_UNIT_MACROS_SVH

// Property checked while the block is out of reset.
`define CRSF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define CRSF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/crsf_pkg.sv
// Shared constants, request codes and types of the rotation finder.
package crsf_pkg;

  localparam int CRSF_MAX_LEN = 64;
  localparam int ELEM_W       = 32;
  localparam int SHIFT_W      = 6;
  localparam int REQ_W        = 2;
  localparam int OUT_W        = 8;

  localparam logic [REQ_W-1:0] REQ_PUSH_FIRST  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_SECOND = 2'd1;
  localparam logic [REQ_W-1:0] REQ_EVALUATE    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } crsf_state_t;

  // Status of the offset scan towards the control.
  typedef struct packed {
    logic done;
    logic found;
  } crsf_scan_stat_t;

endpackage

FILE: rtl/crsf_ram.sv
// Generic single-write, single-read memory with a registered read port.
module crsf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/crsf_seq.sv
// Offset scan: walks every offset, compares both stores word by word, keeps the best distance.
module crsf_seq import crsf_pkg::*; #(
  parameter int MAX_LEN = CRSF_MAX_LEN,
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
  localparam int CW = $clog2(MAX_LEN + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [CW-1:0]     len,
  input  logic [ELEM_W-1:0] rdata_first,
  input  logic [ELEM_W-1:0] rdata_second,
  output logic [AW-1:0]     raddr_first,
  output logic [AW-1:0]     raddr_second,
  output crsf_scan_stat_t   stat,
  output logic [CW-1:0]     best
);

  logic          busy_r, busy_nxt;
  logic          cv_r, cv_nxt;
  logic          cl_r, cl_nxt;
  logic          done_r, done_nxt;
  logic          found_r, found_nxt;
  logic [CW-1:0] best_r, best_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [AW-1:0] off_r, off_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic [AW-1:0] k_r, k_nxt;

  logic          mism, end_off, issue_en;
  logic [CW-1:0] n_m1, off_e, rem, gap;

  assign raddr_first  = j_r;
  assign raddr_second = k_r;
  assign stat.done    = done_r;
  assign stat.found   = found_r;
  assign best         = best_r;

  assign n_m1     = n_r - CW'(1);
  assign off_e    = CW'(off_r);
  assign rem      = n_r - off_e;
  assign gap      = (off_e <= rem) ? off_e : rem;
  assign mism     = rdata_first != rdata_second;
  // An offset ends at its first mismatch or once its last word has compared.
  assign end_off  = cv_r && (mism || cl_r);
  assign issue_en = busy_r && !end_off;

  always_comb begin
    busy_nxt  = busy_r;
    cv_nxt    = 1'b0;
    cl_nxt    = cl_r;
    done_nxt  = 1'b0;
    found_nxt = found_r;
    best_nxt  = best_r;
    n_nxt     = n_r;
    off_nxt   = off_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    if (start) begin
      busy_nxt  = 1'b1;
      found_nxt = 1'b0;
      best_nxt  = '0;
      n_nxt     = len;
      off_nxt   = '0;
      j_nxt     = '0;
      k_nxt     = '0;
    end else if (busy_r) begin
      if (end_off) begin
        if (!mism && (!found_r || gap < best_r)) begin
          found_nxt = 1'b1;
          best_nxt  = gap;
        end
        if (off_e == n_m1) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end else begin
          // The next offset never wraps since it stays below the length.
          off_nxt = off_r + AW'(1);
          j_nxt   = '0;
          k_nxt   = off_r + AW'(1);
        end
      end else if (issue_en) begin
        cv_nxt = 1'b1;
        cl_nxt = CW'(j_r) == n_m1;
        if (CW'(j_r) != n_m1) begin
          j_nxt = j_r + AW'(1);
        end
        k_nxt = (CW'(k_r) == n_m1) ? '0 : k_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cv_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      cv_r   <= cv_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cl_r    <= cl_nxt;
    found_r <= found_nxt;
    best_r  <= best_nxt;
    n_r     <= n_nxt;
    off_r   <= off_nxt;
    j_r     <= j_nxt;
    k_r     <= k_nxt;
  end

endmodule

FILE: rtl/cyclic_rotation_shift_finder_unit.sv
// Top level of the cyclic rotation shift finder.
//
// Input words arrive on in_tvalid/in_tready with the request kind on in_tuser
// and the element on in_tdata. A push of either sequence writes its store
// and gives no result. An evaluate word that can match starts a scan over
// every offset; each evaluate yields one result word on out_tvalid/out_tready.
// No input word is accepted from the evaluate until its result has been
// loaded into the output register.
// The scan reads both stores in step through their one read port each; an
// offset ends at its first mismatch or once all its words have matched. An
// evaluate that cannot match (lengths differ, both empty, overflow) skips
// the scan and goes straight to its result.
// A push beyond the store depth is dropped and flags overflow in the next
// result; every evaluate clears both counts and the flag.
// While the receiver stalls, the result waits in the output register and
// further pushes are still accepted; a following evaluate scans but holds
// its result until the register is free.
// Reset clears the counts, the flag, the scan and the output valid; the
// stores hold nothing meaningful until written.
module cyclic_rotation_shift_finder_unit import crsf_pkg::*; #(
  parameter int MAX_LEN = CRSF_MAX_LEN,
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
  localparam int CW = $clog2(MAX_LEN + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [ELEM_W-1:0] in_tdata,   // [31:0] element
  input  logic [REQ_W-1:0]  in_tuser,   // [1:0] req_type
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata   // [0] is_rotation, [6:1] shift, [7] overflowed
);

  crsf_state_t state_r, state_nxt;

  logic [CW-1:0]      cnt_first_r, cnt_first_nxt;
  logic [CW-1:0]      cnt_second_r, cnt_second_nxt;
  logic               ovf_r, ovf_nxt;
  logic               res_found_r, res_found_nxt;
  logic [CW-1:0]      res_best_r, res_best_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_rot_r, out_rot_nxt;
  logic [SHIFT_W-1:0] out_shift_r, out_shift_nxt;
  logic               out_ovf_r, out_ovf_nxt;

  logic              acc, is_eval, start_scan, load_out;
  logic              we_first, we_second, full_first, full_second;
  logic [AW-1:0]     raddr_first, raddr_second;
  logic [ELEM_W-1:0] rdata_first, rdata_second;
  crsf_scan_stat_t   scan_stat;
  logic [CW-1:0]     scan_best;

  assign acc         = in_tvalid && in_tready;
  assign is_eval     = in_tuser == REQ_EVALUATE;
  assign full_first  = cnt_first_r == CW'(MAX_LEN);
  assign full_second = cnt_second_r == CW'(MAX_LEN);
  assign we_first    = acc && (in_tuser == REQ_PUSH_FIRST) && !full_first;
  assign we_second   = acc && (in_tuser == REQ_PUSH_SECOND) && !full_second;
  assign start_scan  = acc && is_eval && !ovf_r && (cnt_first_r == cnt_second_r)
                       && (cnt_first_r != '0);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc && is_eval) begin
          state_nxt = start_scan ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (scan_stat.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_tready = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_SCAN: ;
      ST_DONE: load_out = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  always_comb begin
    cnt_first_nxt  = cnt_first_r;
    cnt_second_nxt = cnt_second_r;
    ovf_nxt        = ovf_r;
    res_found_nxt  = res_found_r;
    res_best_nxt   = res_best_r;
    out_rot_nxt    = out_rot_r;
    out_shift_nxt  = out_shift_r;
    out_ovf_nxt    = out_ovf_r;
    out_valid_nxt  = out_tready ? 1'b0 : out_valid_r;
    if (acc && (in_tuser == REQ_PUSH_FIRST)) begin
      if (full_first) begin
        ovf_nxt = 1'b1;
      end else begin
        cnt_first_nxt = cnt_first_r + CW'(1);
      end
    end
    if (acc && (in_tuser == REQ_PUSH_SECOND)) begin
      if (full_second) begin
        ovf_nxt = 1'b1;
      end else begin
        cnt_second_nxt = cnt_second_r + CW'(1);
      end
    end
    if (acc && is_eval) begin
      res_found_nxt = 1'b0;
      res_best_nxt  = '0;
    end
    if (scan_stat.done) begin
      res_found_nxt = scan_stat.found;
      res_best_nxt  = scan_best;
    end
    if (load_out) begin
      out_valid_nxt  = 1'b1;
      out_rot_nxt    = res_found_r;
      out_shift_nxt  = res_found_r ? SHIFT_W'(res_best_r) : '0;
      out_ovf_nxt    = ovf_r;
      cnt_first_nxt  = '0;
      cnt_second_nxt = '0;
      ovf_nxt        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_first_r  <= '0;
      cnt_second_r <= '0;
      ovf_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_first_r  <= cnt_first_nxt;
      cnt_second_r <= cnt_second_nxt;
      ovf_r        <= ovf_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_found_r <= res_found_nxt;
    res_best_r  <= res_best_nxt;
    out_rot_r   <= out_rot_nxt;
    out_shift_r <= out_shift_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_ovf_r, out_shift_r, out_rot_r};

  crsf_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (MAX_LEN)
  ) u_first_store (
    .clk   (clk),
    .we    (we_first),
    .waddr (cnt_first_r[AW-1:0]),
    .wdata (in_tdata),
    .raddr (raddr_first),
    .rdata (rdata_first)
  );

  crsf_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (MAX_LEN)
  ) u_second_store (
    .clk   (clk),
    .we    (we_second),
    .waddr (cnt_second_r[AW-1:0]),
    .wdata (in_tdata),
    .raddr (raddr_second),
    .rdata (rdata_second)
  );

  crsf_seq #(
    .MAX_LEN (MAX_LEN)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start_scan),
    .len          (cnt_first_r),
    .rdata_first  (rdata_first),
    .rdata_second (rdata_second),
    .raddr_first  (raddr_first),
    .raddr_second (raddr_second),
    .stat         (scan_stat),
    .best         (scan_best)
  );

endmodule

FILE: rtl/crsf_checker.sv
// Port-level checker of the rotation finder and its bind to the top level.
`include "cyclic_rotation_shift_finder_unit_macros.svh"

module crsf_checker import crsf_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic [ELEM_W-1:0] in_tdata,
  input logic [REQ_W-1:0]  in_tuser,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_W-1:0]  out_tdata
);

  // A waiting result word stays until it is taken.
  `CRSF_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result word dropped")

  // A result without a match carries a zero distance.
  `CRSF_ASSERT(a_shift_zero, out_tvalid && !out_tdata[0] |-> out_tdata[6:1] == '0, "shift set without match")

  // An accepted evaluate closes the input until its result is loaded.
  `CRSF_ASSERT(a_eval_busy, in_tvalid && in_tready && in_tuser == REQ_EVALUATE |=> !in_tready, "input open during evaluation")

  // A new result only appears at the end of an evaluation.
  `CRSF_ASSERT(a_out_after_eval, $rose(out_tvalid) |-> $past(!in_tready), "result without evaluation")

  // Reset leaves no result pending.
  `CRSF_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind cyclic_rotation_shift_finder_unit crsf_checker u_crsf_checker (.*);
